FILE: rtl/dcp_pkg.sv
// Shared constants for the distance constraint projector.
package dcp_pkg;

  // Default coordinate width (signed fixed point, all axes share one scale)
  localparam int COORD_BITS_DEF = 24;

  // Stiffness register: unsigned Q1.16, 65536 means a gain of one
  localparam int STIFF_BITS = 17;
  localparam logic [STIFF_BITS-1:0] STIFF_RESET = 17'd32768;

  // Extra fraction bits of the error factor and the rounding shift
  localparam int Q_FRAC      = 16;
  localparam int ROUND_SHIFT = 32;

endpackage

FILE: rtl/distance_constraint_projector_unit.sv
// Top level of the distance constraint projector pipeline.
//
// Usage: each in_ transaction carries one distance constraint (two particle
// positions, rest length, movable flags); each out_ transaction returns the
// corrected positions of that constraint, one result per input, in order.
// The cfg_ channel writes the stiffness gain (Q1.16); it is always ready and
// should only be written while no constraint is in flight.
// The square root stage (one root bit per stage) and the divider
// (one quotient bit per stage) set the pipeline depth.
// Throughput: one constraint per cycle while no result is stalled;
// every stage is a register stage.
// When the receiver stalls a result, the whole pipeline holds in place and
// in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the stiffness register with 0.5.
// A zero separation passes both positions through and sets degenerate.
module distance_constraint_projector_unit #(
  parameter  int COORD_BITS = dcp_pkg::COORD_BITS_DEF,
  localparam int IN_W       = ((7 * COORD_BITS - 1 + 7) / 8) * 8,
  localparam int OUT_W      = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: a_x, a_y, a_z, b_x, b_y, b_z, rest_length, zero fill
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,
  // in_tuser: a_movable, b_movable
  input  logic [1:0]                    in_tuser,
  // out_tdata: new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,
  // out_tuser: degenerate
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcp_pkg::STIFF_BITS-1:0] cfg_data
);

  localparam int CW     = COORD_BITS;
  localparam int RW     = CW - 1;
  localparam int SW     = CW + 1;
  localparam int KW     = dcp_pkg::STIFF_BITS;
  localparam int QW     = SW + KW + dcp_pkg::Q_FRAC;
  localparam int SIDE_W = 9 * CW + 5;
  localparam int PW     = CW + QW;
  localparam int H      = QW / 2;
  localparam int RS     = dcp_pkg::ROUND_SHIFT;
  localparam int CMW    = PW + 1 - RS;
  localparam int SUM_W  = CMW + 2;

  logic en;

  // Stall everything while a finished result waits
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Stiffness register
  logic [KW-1:0] stiff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= dcp_pkg::STIFF_RESET;
    end else if (cfg_valid) begin
      stiff_r <= cfg_data;
    end
  end

  // Stage 1: separation, its magnitude and sign per axis
  logic              s1_vld_r;
  logic [SIDE_W-1:0] s1_side_r;
  logic [RW-1:0]     s1_rest_r;
  logic [SIDE_W-1:0] s1_side_nxt;

  always_comb begin
    logic [CW-1:0] ac;
    logic [CW-1:0] bc;
    logic [CW:0]   d;
    logic [CW:0]   dabs;
    s1_side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      ac   = in_tdata[CW*i +: CW];
      bc   = in_tdata[CW*(3+i) +: CW];
      d    = {bc[CW-1], bc} - {ac[CW-1], ac};
      dabs = d[CW] ? (~d + 1'b1) : d;
      s1_side_nxt[CW*i +: CW]     = ac;
      s1_side_nxt[CW*(3+i) +: CW] = bc;
      s1_side_nxt[CW*(6+i) +: CW] = dabs[CW-1:0];
      s1_side_nxt[9*CW + i]       = d[CW];
    end
    s1_side_nxt[9*CW + 3] = in_tuser[0];
    s1_side_nxt[9*CW + 4] = in_tuser[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_rest_r <= in_tdata[6*CW +: RW];
    end
  end

  // Stage 2: squares of the axis magnitudes
  logic              s2_vld_r;
  logic [SIDE_W-1:0] s2_side_r;
  logic [RW-1:0]     s2_rest_r;
  logic [2*CW-1:0]   s2_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s1_side_r;
      s2_rest_r <= s1_rest_r;
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= s1_side_r[CW*(6+i) +: CW] * s1_side_r[CW*(6+i) +: CW];
      end
    end
  end

  // Stage 3: squared length
  logic              s3_vld_r;
  logic [SIDE_W-1:0] s3_side_r;
  logic [RW-1:0]     s3_rest_r;
  logic [2*SW-1:0]   s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s2_side_r;
      s3_rest_r <= s2_rest_r;
      s3_sum_r  <= (2*SW)'(s2_sq_r[0]) + (2*SW)'(s2_sq_r[1]) + (2*SW)'(s2_sq_r[2]);
    end
  end

  // Length by pipelined square root
  logic                 rt_vld;
  logic [SW-1:0]        rt_dist;
  logic [RW+SIDE_W-1:0] rt_pay;

  dcp_sqrt #(
    .ROOT_W (SW),
    .PAY_W  (RW + SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .radicand  (s3_sum_r),
    .in_pay    ({s3_rest_r, s3_side_r}),
    .out_valid (rt_vld),
    .root      (rt_dist),
    .out_pay   (rt_pay)
  );

  // Stage 4: length error and its sign
  logic              s4_vld_r;
  logic [SIDE_W-1:0] s4_side_r;
  logic              s4_degen_r;
  logic              s4_neg_r;
  logic [SW-1:0]     s4_mag_r;
  logic [SW-1:0]     s4_dist_r;
  logic [SW-1:0]     rest_ext;

  assign rest_ext = SW'(rt_pay[SIDE_W +: RW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r  <= rt_pay[SIDE_W-1:0];
      s4_degen_r <= (rt_dist == '0);
      s4_neg_r   <= (rt_dist < rest_ext);
      s4_mag_r   <= (rt_dist < rest_ext) ? (rest_ext - rt_dist) : (rt_dist - rest_ext);
      s4_dist_r  <= rt_dist;
    end
  end

  // Stage 5: scale the error by stiffness
  logic              s5_vld_r;
  logic [SIDE_W-1:0] s5_side_r;
  logic              s5_degen_r;
  logic              s5_neg_r;
  logic [SW+KW-1:0]  s5_prod_r;
  logic [SW-1:0]     s5_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r  <= s4_side_r;
      s5_degen_r <= s4_degen_r;
      s5_neg_r   <= s4_neg_r;
      s5_prod_r  <= s4_mag_r * stiff_r;
      s5_dist_r  <= s4_dist_r;
    end
  end

  // Error factor by pipelined division
  logic              dv_vld;
  logic [QW-1:0]     dv_q;
  logic [SIDE_W+1:0] dv_pay;

  dcp_div #(
    .NUM_W (QW),
    .DIV_W (SW),
    .PAY_W (SIDE_W + 2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_vld_r),
    .numer     ({s5_prod_r, {dcp_pkg::Q_FRAC{1'b0}}}),
    .denom     (s5_dist_r),
    .in_pay    ({s5_degen_r, s5_neg_r, s5_side_r}),
    .out_valid (dv_vld),
    .quot      (dv_q),
    .out_pay   (dv_pay)
  );

  // Stage 6: partial products of magnitude and factor
  logic              s6_vld_r;
  logic [SIDE_W-1:0] s6_side_r;
  logic              s6_degen_r;
  logic              s6_neg_r;
  logic [CW+H-1:0]   s6_lo_r [3];
  logic [PW-H-1:0]   s6_hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r  <= dv_pay[SIDE_W-1:0];
      s6_neg_r   <= dv_pay[SIDE_W];
      s6_degen_r <= dv_pay[SIDE_W+1];
      for (int i = 0; i < 3; i++) begin
        s6_lo_r[i] <= dv_pay[CW*(6+i) +: CW] * dv_q[H-1:0];
        s6_hi_r[i] <= dv_pay[CW*(6+i) +: CW] * dv_q[QW-1:H];
      end
    end
  end

  // Stage 7: combine partial products and round
  logic              s7_vld_r;
  logic [SIDE_W-1:0] s7_side_r;
  logic              s7_degen_r;
  logic              s7_neg_r;
  logic [CMW-1:0]    s7_cm_r [3];
  logic [PW:0]       full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = (PW+1)'(s6_lo_r[i]) + ((PW+1)'(s6_hi_r[i]) << H)
              + ((PW+1)'(1) << (RS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r  <= s6_side_r;
      s7_degen_r <= s6_degen_r;
      s7_neg_r   <= s6_neg_r;
      for (int i = 0; i < 3; i++) begin
        s7_cm_r[i] <= full[i][PW:RS];
      end
    end
  end

  // Stage 8: apply corrections with saturation
  logic [OUT_W-1:0] out_data_nxt;

  always_comb begin
    logic [CW-1:0]    ac;
    logic [CW-1:0]    bc;
    logic [SUM_W-1:0] ae;
    logic [SUM_W-1:0] be;
    logic [SUM_W-1:0] ce;
    logic [SUM_W-1:0] asum;
    logic [SUM_W-1:0] bsum;
    logic [CW-1:0]    anew;
    logic [CW-1:0]    bnew;
    logic             flip;
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      ac   = s7_side_r[CW*i +: CW];
      bc   = s7_side_r[CW*(3+i) +: CW];
      ae   = {{(SUM_W-CW){ac[CW-1]}}, ac};
      be   = {{(SUM_W-CW){bc[CW-1]}}, bc};
      ce   = {2'b00, s7_cm_r[i]};
      flip = s7_neg_r ^ s7_side_r[9*CW + i];
      asum = flip ? (ae - ce) : (ae + ce);
      bsum = flip ? (be + ce) : (be - ce);
      // Clamp where the upper bits are not all sign copies
      if (asum[SUM_W-1:CW-1] == '0 || asum[SUM_W-1:CW-1] == '1) begin
        anew = asum[CW-1:0];
      end else begin
        anew = {asum[SUM_W-1], {(CW-1){~asum[SUM_W-1]}}};
      end
      if (bsum[SUM_W-1:CW-1] == '0 || bsum[SUM_W-1:CW-1] == '1) begin
        bnew = bsum[CW-1:0];
      end else begin
        bnew = {bsum[SUM_W-1], {(CW-1){~bsum[SUM_W-1]}}};
      end
      // Hold pinned particles and degenerate pairs
      if (s7_degen_r || !s7_side_r[9*CW + 3]) begin
        anew = ac;
      end
      if (s7_degen_r || !s7_side_r[9*CW + 4]) begin
        bnew = bc;
      end
      out_data_nxt[CW*i +: CW]     = anew;
      out_data_nxt[CW*(3+i) +: CW] = bnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata    <= out_data_nxt;
      out_tuser[0] <= s7_degen_r;
    end
  end

endmodule

FILE: rtl/dcp_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module dcp_sqrt #(
  parameter int ROOT_W = 25,
  parameter int PAY_W  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [PAY_W-1:0]      in_pay,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [PAY_W-1:0]      out_pay
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [PAY_W-1:0]  pay_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [PAY_W-1:0]  pay_i;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;

    // Pick up the previous stage, or the unit inputs at the head
    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rad_i  = radicand;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = in_pay;
    end else begin : g_body
      assign v_i    = vld_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_i, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_r[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r[k] <= {root_i[ROOT_W-2:0], take};
        pay_r[k]  <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign out_pay   = pay_r[ROOT_W-1];

endmodule

FILE: rtl/dcp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module dcp_div #(
  parameter int NUM_W = 58,
  parameter int DIV_W = 25,
  parameter int PAY_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DIV_W-1:0]  denom,
  input  logic [PAY_W-1:0]  in_pay,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [PAY_W-1:0]  out_pay
);

  logic             vld_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DIV_W-1:0] den_r [NUM_W];
  logic [DIV_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [PAY_W-1:0] pay_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_i;
    logic [NUM_W-1:0] num_i;
    logic [DIV_W-1:0] den_i;
    logic [DIV_W-1:0] rem_i;
    logic [NUM_W-1:0] quo_i;
    logic [PAY_W-1:0] pay_i;
    logic [DIV_W:0]   rem_sh;
    logic             take;

    // Pick up the previous stage, or the unit inputs at the head
    if (k == 0) begin : g_head
      assign v_i   = in_valid;
      assign num_i = numer;
      assign den_i = denom;
      assign rem_i = '0;
      assign quo_i = '0;
      assign pay_i = in_pay;
    end else begin : g_body
      assign v_i   = vld_r[k-1];
      assign num_i = num_r[k-1];
      assign den_i = den_r[k-1];
      assign rem_i = rem_r[k-1];
      assign quo_i = quo_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    // Shift in the next numerator bit and subtract where it fits
    assign rem_sh = {rem_i, num_i[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[NUM_W-2:0], 1'b0};
        den_r[k] <= den_i;
        rem_r[k] <= take ? DIV_W'(rem_sh - {1'b0, den_i}) : DIV_W'(rem_sh);
        quo_r[k] <= {quo_i[NUM_W-2:0], take};
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign quot      = quo_r[NUM_W-1];
  assign out_pay   = pay_r[NUM_W-1];

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the distance constraint projector unit.
module testbench;

  localparam int CB    = 24;
  localparam int IN_W  = 168;
  localparam int OUT_W = 144;
  localparam int LATENCY   = 91;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] na_x, na_y, na_z, nb_x, nb_y, nb_z;
    logic          degen;
  } position_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dcp_pkg::STIFF_BITS-1:0] cfg_data = '0;

  logic [dcp_pkg::STIFF_BITS-1:0] gain;
  position_t expected_positions[$];
  int  mismatch_count = 0;
  int  constraint_count = 0;
  int  result_count = 0;
  int  degen_count = 0;
  int  out_idle_pct = 36;
  longint cycle_count = 0;

  distance_constraint_projector_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] clamp(input longint v);
    if (v > 64'sd8388607) return 24'h7fffff;
    if (v < -64'sd8388608) return 24'h800000;
    return v[CB-1:0];
  endfunction

  // Project one constraint with the current gain
  function automatic position_t project_constraint(input logic [IN_W-1:0] data,
                                                   input logic [1:0] movable);
    longint a[3], b[3], d[3];
    longint na[3], nb[3];
    logic [63:0] sumsq, sep_len, rest, mag, q, dm, cm;
    longint corr;
    logic   neg_f, dneg;
    position_t r;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(data[i*CB +: CB]));
      b[i] = longint'($signed(data[(i+3)*CB +: CB]));
      d[i] = b[i] - a[i];
      dm = (d[i] < 0) ? -d[i] : d[i];
      sumsq = sumsq + dm * dm;
      na[i] = a[i];
      nb[i] = b[i];
    end
    rest = 64'(data[6*CB +: 23]);
    sep_len = isqrt(sumsq);
    r.degen = (sep_len == 0);
    if (sep_len != 0) begin
      neg_f = (sep_len < rest);
      mag = neg_f ? rest - sep_len : sep_len - rest;
      q = ((mag * gain) << 16) / sep_len;
      for (int i = 0; i < 3; i++) begin
        dneg = d[i] < 0;
        dm = dneg ? -d[i] : d[i];
        cm = (dm * q + (64'd1 << 31)) >> 32;
        corr = (neg_f != dneg) ? -longint'(cm) : longint'(cm);
        if (movable[0]) na[i] = a[i] + corr;
        if (movable[1]) nb[i] = b[i] - corr;
      end
    end
    r.na_x = clamp(na[0]); r.na_y = clamp(na[1]); r.na_z = clamp(na[2]);
    r.nb_x = clamp(nb[0]); r.nb_y = clamp(nb[1]); r.nb_z = clamp(nb[2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CB-1:0] got,
                                 input logic [CB-1:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %h expected %h",
             result_count, what, got, want);
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    position_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result new_a_x", out_tdata[0*CB +: CB], '0);
      end else begin
        e = expected_positions.pop_front();
        if (out_tdata[0*CB +: CB] !== e.na_x) report_mismatch("new_a_x", out_tdata[0*CB +: CB], e.na_x);
        if (out_tdata[1*CB +: CB] !== e.na_y) report_mismatch("new_a_y", out_tdata[1*CB +: CB], e.na_y);
        if (out_tdata[2*CB +: CB] !== e.na_z) report_mismatch("new_a_z", out_tdata[2*CB +: CB], e.na_z);
        if (out_tdata[3*CB +: CB] !== e.nb_x) report_mismatch("new_b_x", out_tdata[3*CB +: CB], e.nb_x);
        if (out_tdata[4*CB +: CB] !== e.nb_y) report_mismatch("new_b_y", out_tdata[4*CB +: CB], e.nb_y);
        if (out_tdata[5*CB +: CB] !== e.nb_z) report_mismatch("new_b_z", out_tdata[5*CB +: CB], e.nb_z);
        if (out_tuser[0] !== e.degen) report_mismatch("degenerate", CB'(out_tuser), CB'(e.degen));
        if (e.degen) degen_count++;
      end
      result_count++;
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Send one constraint transaction, optionally idling first
  task automatic send_constraint(input logic [CB-1:0] ax, ay, az, bx, by, bz,
                                 input logic [22:0] rest, input logic [1:0] mov,
                                 input int idle_pct);
    logic [IN_W-1:0] data;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    data = {1'b0, rest, bz, by, bx, az, ay, ax};
    in_tdata  <= data;
    in_tuser  <= mov;
    in_tvalid <= 1'b1;
    expected_positions.push_back(project_constraint(data, mov));
    constraint_count++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_stiffness(input logic [dcp_pkg::STIFF_BITS-1:0] value);
    drain_pipeline();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CB-1:0] rand_coord(input int spread);
    case ($urandom_range(3))
      0: return CB'($urandom());
      1: return CB'($signed($urandom_range(2 * spread)) - spread);
      2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return CB'($urandom_range(4095));
    endcase
  endfunction

  // Extremes, pins, zero separation, stretched and compressed pairs
  task automatic test_directed();
    send_constraint('0, '0, '0, '0, '0, '0, '0, 2'b11, 0);
    send_constraint(24'd100, -24'sd5, 24'd7, 24'd100, -24'sd5, 24'd7,
                    23'h7fffff, 2'b11, 0);
    send_constraint('0, '0, '0, 24'd256, '0, '0, 23'd128, 2'b11, 0);
    send_constraint('0, '0, '0, 24'd256, '0, '0, 23'd128, 2'b01, 0);
    send_constraint('0, '0, '0, 24'd256, '0, '0, 23'd128, 2'b10, 0);
    send_constraint('0, '0, '0, 24'd256, '0, '0, 23'd128, 2'b00, 0);
    send_constraint('0, '0, '0, '0, 24'd300, -24'sd400, 23'd1000, 2'b11, 0);
    send_constraint(24'h800000, 24'h800000, 24'h800000,
                    24'h7fffff, 24'h7fffff, 24'h7fffff, '0, 2'b11, 0);
    send_constraint(24'h7fffff, 24'h800000, 24'h7fffff,
                    24'h800000, 24'h7fffff, 24'h800000, 23'h7fffff, 2'b11, 0);
    send_constraint(24'd10, 24'd10, 24'd10, 24'd11, 24'd10, 24'd10, 23'h7fffff, 2'b11, 0);
    send_constraint(-24'sd3, 24'd4, '0, '0, '0, '0, 23'd5, 2'b11, 0);
    send_constraint(24'h555555, 24'haaaaaa, 24'h0f0f0f,
                    24'haaaaaa, 24'h555555, 24'hf0f0f0, 23'h2aaaaa, 2'b11, 0);
  endtask

  // Random constraints: mostly near rest length, some wild
  task automatic test_random(input int count, input int idle_pct);
    logic [CB-1:0] ax, ay, az, bx, by, bz;
    logic [22:0] rest;
    int spread;
    for (int n = 0; n < count; n++) begin
      spread = ($urandom_range(3) == 0) ? 8388607 : int'($urandom_range(20000)) + 1;
      ax = rand_coord(spread); ay = rand_coord(spread); az = rand_coord(spread);
      if ($urandom_range(15) == 0) begin
        bx = ax; by = ay; bz = az;
      end else begin
        bx = ax + CB'($signed($urandom_range(2 * spread)) - spread);
        by = ay + CB'($signed($urandom_range(2 * spread)) - spread);
        bz = az + CB'($signed($urandom_range(2 * spread)) - spread);
      end
      rest = ($urandom_range(3) == 0) ? 23'($urandom()) : 23'($urandom_range(2 * spread));
      send_constraint(ax, ay, az, bx, by, bz, rest, 2'($urandom_range(3)), idle_pct);
    end
  endtask

  initial begin
    gain = dcp_pkg::STIFF_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(300, 36);
    write_stiffness(17'd65536);
    test_directed();
    test_random(250, 36);
    write_stiffness(17'd0);
    test_random(150, 36);
    write_stiffness(17'h1ffff);
    test_directed();
    test_random(200, 36);
    write_stiffness(17'($urandom_range(65536)));
    // back-to-back stretch with the receiver always ready
    out_idle_pct = 0;
    test_random(250, 0);
    out_idle_pct = 36;
    // hold off until every expected result is back, then resume
    drain_pipeline();
    write_stiffness(17'd1);
    test_random(250, 36);

    drain_pipeline();
    $display("covered %0d constraints, %0d results, %0d degenerate, six stiffness settings",
             constraint_count, result_count, degen_count);
    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/dcp_pkg.sv
rtl/dcp_sqrt.sv
rtl/dcp_div.sv
rtl/distance_constraint_projector_unit.sv
verif/testbench.sv
